// ===== rtl/redh_pkg.sv =====
// Shared types and constants for the range end point deduplication block.
// No dependencies; every other file in rtl/ depends on this package.
package redh_pkg;

  // Fixed field widths
  localparam int POINT_W = 32;
  localparam int IDX_W   = 12;
  localparam int MOD_W   = 12;

  // Table modulus after reset
  localparam logic [MOD_W-1:0] MODULUS_RST = 12'd1999;

  // Default sizing
  localparam int BUCKETS_DEF      = 2048;
  localparam int BUCKET_DEPTH_DEF = 8;
  localparam int MAX_POINTS_DEF   = 4096;

  // Set generation tag kept with each bucket fill count
  localparam int EPOCH_W = 8;

  typedef logic [POINT_W-1:0] point_t;
  typedef logic [MOD_W-1:0]   modulus_t;

endpackage

// ===== rtl/redh_mod_unit.sv =====
// Iterative restoring modulo unit: one quotient bit per cycle.
// Depends on redh_pkg.
module redh_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  redh_pkg::point_t  dividend,
  input  redh_pkg::modulus_t divisor,
  output logic              done,
  output redh_pkg::modulus_t remainder
);
  import redh_pkg::*;

  localparam int CNT_W = $clog2(POINT_W + 1);

  point_t             dvd_r;
  modulus_t           div_r;
  modulus_t           rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;
  logic [MOD_W:0]     shifted;
  logic [MOD_W:0]     diff;
  logic               take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, dvd_r[POINT_W-1]};
    diff    = shifted - {1'b0, div_r};
    take    = (shifted >= {1'b0, div_r});
  end

  // Control: load on start, count down the steps, flag the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(POINT_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: hold the remainder once finished
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[POINT_W-2:0], 1'b0};
      rem_r <= take ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/redh_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on redh_pkg for default sizing.
module redh_ram #(
  parameter int W     = redh_pkg::POINT_W,
  parameter int DEPTH = redh_pkg::BUCKETS_DEF * redh_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/range_endpoint_dedup_hash_top.sv =====
// Top level: sequencer, shared modulo unit, bucket fill and bucket store memories.
// Each end point passes through start, modulo, fill read, 0 to BUCKET_DEPTH bucket compares,
// an append or overflow report when new, and an advance. A transaction yields 0 to 2 results,
// each held back by any output stall; input stalls until the transaction is done.
// Synchronous reset runs a clearing pass over all BUCKETS fill memory entries before the
// first transaction, and every 256th start_set repeats it when the set tag wraps.
module range_endpoint_dedup_hash_top #(
  parameter int BUCKETS      = redh_pkg::BUCKETS_DEF,
  parameter int BUCKET_DEPTH = redh_pkg::BUCKET_DEPTH_DEF,
  parameter int MAX_POINTS   = redh_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  redh_pkg::modulus_t         cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  redh_pkg::point_t           in_range_low,
  input  redh_pkg::point_t           in_range_high,
  input  logic                       in_start_set,
  output logic                       out_valid,
  input  logic                       out_stall,
  output redh_pkg::point_t           out_new_point,
  output logic [redh_pkg::IDX_W-1:0] out_point_index,
  output logic                       out_overflow,
  output logic                       out_last_result
);
  import redh_pkg::*;

  localparam int BIDX_W = $clog2(BUCKETS);
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SDEPTH = BUCKETS * BUCKET_DEPTH;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int FMEM_W = EPOCH_W + FILL_W;

  // Sequencer states
  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_START  = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_FILL   = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_DECIDE = 4'd6;
  localparam logic [3:0] ST_NEXT   = 4'd7;
  localparam logic [3:0] ST_EMIT0  = 4'd8;
  localparam logic [3:0] ST_EMIT1  = 4'd9;

  logic [3:0]         state_r, state_nxt;
  modulus_t           cfg_mod_r;
  point_t             lo_r, lo_nxt;
  point_t             hi_r, hi_nxt;
  point_t             cur_pt_r, cur_pt_nxt;
  logic               hi_phase_r, hi_phase_nxt;
  logic               busy_r, busy_nxt;
  logic [BIDX_W-1:0]  bucket_r, bucket_nxt;
  logic [FILL_W-1:0]  n_r, n_nxt;
  logic [FILL_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [BIDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [1:0]         nres_r, nres_nxt;
  point_t             r0_pt_r, r0_pt_nxt, r1_pt_r, r1_pt_nxt;
  logic [IDX_W-1:0]   r0_idx_r, r0_idx_nxt, r1_idx_r, r1_idx_nxt;
  logic               r0_ovf_r, r0_ovf_nxt, r1_ovf_r, r1_ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  point_t             out_pt_r, out_pt_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_last_r, out_last_nxt;

  modulus_t           eff_mod;
  logic               mod_start;
  logic               mod_done;
  modulus_t           mod_rem;

  logic               fill_we;
  logic [BIDX_W-1:0]  fill_waddr;
  logic [FMEM_W-1:0]  fill_wdata;
  logic [FMEM_W-1:0]  fill_rdata;
  logic [FILL_W-1:0]  fill_now;

  logic               store_we;
  logic [SA_W-1:0]    store_waddr;
  logic [SA_W-1:0]    store_raddr;
  logic [FILL_W-1:0]  store_ridx;
  point_t             store_rdata;

  logic               can_load;
  logic               is_full;

  // Clamp the configured modulus to 1 .. BUCKETS
  always_comb begin
    if (cfg_mod_r == '0) begin
      eff_mod = MOD_W'(1);
    end else if (32'(cfg_mod_r) > 32'(BUCKETS)) begin
      eff_mod = MOD_W'(BUCKETS);
    end else begin
      eff_mod = cfg_mod_r;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mod_r <= MODULUS_RST;
    end else if (cfg_wr_en) begin
      cfg_mod_r <= cfg_wr_data;
    end
  end

  // Shared modulo unit
  redh_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (cur_pt_r),
    .divisor   (eff_mod),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Bucket fill counts, tagged with the set generation
  redh_ram #(.W(FMEM_W), .DEPTH(BUCKETS)) u_fill (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_waddr),
    .wr_data (fill_wdata),
    .rd_addr (BIDX_W'(mod_rem)),
    .rd_data (fill_rdata)
  );

  // Stored points, BUCKET_DEPTH slots per bucket
  redh_ram #(.W(POINT_W), .DEPTH(SDEPTH)) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_waddr),
    .wr_data (cur_pt_r),
    .rd_addr (store_raddr),
    .rd_data (store_rdata)
  );

  // Fill count of a bucket last written in an older set reads as empty
  assign fill_now = (fill_rdata[FMEM_W-1:FILL_W] == epoch_r) ? fill_rdata[FILL_W-1:0] : '0;

  // Store addressing: slot zero on the fill cycle, then the next slot
  assign store_ridx  = (state_r == ST_FILL) ? '0 : FILL_W'(i_r + 1'b1);
  assign store_raddr = SA_W'(SA_W'(bucket_r) * SA_W'(BUCKET_DEPTH) + SA_W'(store_ridx));
  assign store_waddr = SA_W'(SA_W'(bucket_r) * SA_W'(BUCKET_DEPTH) + SA_W'(n_r));

  assign is_full  = (n_r >= FILL_W'(BUCKET_DEPTH)) || (count_r >= CNT_W'(MAX_POINTS));
  assign can_load = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    cur_pt_nxt   = cur_pt_r;
    hi_phase_nxt = hi_phase_r;
    busy_nxt     = busy_r;
    bucket_nxt   = bucket_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    count_nxt    = count_r;
    epoch_nxt    = epoch_r;
    clr_addr_nxt = clr_addr_r;
    nres_nxt     = nres_r;
    r0_pt_nxt    = r0_pt_r;
    r0_idx_nxt   = r0_idx_r;
    r0_ovf_nxt   = r0_ovf_r;
    r1_pt_nxt    = r1_pt_r;
    r1_idx_nxt   = r1_idx_r;
    r1_ovf_nxt   = r1_ovf_r;
    out_pt_nxt   = out_pt_r;
    out_idx_nxt  = out_idx_r;
    out_ovf_nxt  = out_ovf_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    mod_start    = 1'b0;
    fill_we      = 1'b0;
    fill_waddr   = bucket_r;
    fill_wdata   = {epoch_r, FILL_W'(n_r + 1'b1)};
    store_we     = 1'b0;

    case (state_r)
      // Sweep the fill memory to empty under the current tag
      ST_CLR: begin
        fill_we      = 1'b1;
        fill_waddr   = clr_addr_r;
        fill_wdata   = {epoch_r, {FILL_W{1'b0}}};
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == BIDX_W'(BUCKETS - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = busy_r ? ST_START : ST_IDLE;
        end
      end
      // Take a transaction; a new set bumps the tag
      ST_IDLE: begin
        if (in_valid) begin
          lo_nxt       = in_range_low;
          hi_nxt       = in_range_high;
          cur_pt_nxt   = in_range_low;
          hi_phase_nxt = 1'b0;
          nres_nxt     = '0;
          busy_nxt     = 1'b1;
          state_nxt    = ST_START;
          if (in_start_set) begin
            count_nxt = '0;
            epoch_nxt = epoch_r + 1'b1;
            if (epoch_nxt == '0) begin
              state_nxt = ST_CLR;
            end
          end
        end
      end
      ST_START: begin
        mod_start = 1'b1;
        state_nxt = ST_DIV;
      end
      // Wait for the bucket number; fill read goes out on the final step
      ST_DIV: begin
        if (mod_done) begin
          bucket_nxt = BIDX_W'(mod_rem);
          state_nxt  = ST_FILL;
        end
      end
      ST_FILL: begin
        n_nxt = fill_now;
        i_nxt = '0;
        state_nxt = (fill_now == '0) ? ST_DECIDE : ST_WALK;
      end
      // Compare one stored point per cycle
      ST_WALK: begin
        if (store_rdata == cur_pt_r) begin
          state_nxt = ST_NEXT;
        end else if (FILL_W'(i_r + 1'b1) == n_r) begin
          state_nxt = ST_DECIDE;
        end else begin
          i_nxt = FILL_W'(i_r + 1'b1);
        end
      end
      // Append the point, or report overflow
      ST_DECIDE: begin
        if (nres_r == '0) begin
          r0_pt_nxt  = cur_pt_r;
          r0_idx_nxt = is_full ? '0 : IDX_W'(count_r);
          r0_ovf_nxt = is_full;
        end else begin
          r1_pt_nxt  = cur_pt_r;
          r1_idx_nxt = is_full ? '0 : IDX_W'(count_r);
          r1_ovf_nxt = is_full;
        end
        nres_nxt = nres_r + 1'b1;
        if (!is_full) begin
          fill_we   = 1'b1;
          store_we  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = ST_NEXT;
      end
      // Advance to the high point, or hand over the results (back to idle when there are none)
      ST_NEXT: begin
        if (!hi_phase_r && (hi_r != lo_r)) begin
          hi_phase_nxt = 1'b1;
          cur_pt_nxt   = hi_r;
          state_nxt    = ST_START;
        end else if (nres_r == '0) begin
          busy_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT0;
        end
      end
      ST_EMIT0: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_pt_nxt    = r0_pt_r;
          out_idx_nxt   = r0_idx_r;
          out_ovf_nxt   = r0_ovf_r;
          out_last_nxt  = (nres_r == 2'd1);
          if (nres_r == 2'd1) begin
            busy_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT1;
          end
        end
      end
      ST_EMIT1: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_pt_nxt    = r1_pt_r;
          out_idx_nxt   = r1_idx_r;
          out_ovf_nxt   = r1_ovf_r;
          out_last_nxt  = 1'b1;
          busy_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      busy_r      <= 1'b0;
      hi_phase_r  <= 1'b0;
      count_r     <= '0;
      epoch_r     <= '0;
      clr_addr_r  <= '0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      hi_phase_r  <= hi_phase_nxt;
      count_r     <= count_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
      nres_r      <= nres_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_pt_r   <= cur_pt_nxt;
    bucket_r   <= bucket_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    r0_pt_r    <= r0_pt_nxt;
    r0_idx_r   <= r0_idx_nxt;
    r0_ovf_r   <= r0_ovf_nxt;
    r1_pt_r    <= r1_pt_nxt;
    r1_idx_r   <= r1_idx_nxt;
    r1_ovf_r   <= r1_ovf_nxt;
    out_pt_r   <= out_pt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_new_point   = out_pt_r;
  assign out_point_index = out_idx_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_result = out_last_r;

endmodule
